// ===== hdl/vtp_pkg.sv =====
// Shared types, widths and helpers for the vertex transform pipeline.
package vtp_pkg;

  localparam int NUM_REGS    = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int FRAC_BITS   = 16;
  localparam int WIDE_W      = 50;   // transformed component, floor of Q32.32 sum
  localparam int DIV_NUM_W   = 49;   // dividend magnitude
  localparam int DIV_DEN_W   = 32;   // divisor magnitude
  localparam int DIV_STEPS   = DIV_NUM_W;

  localparam logic [1:0] MODE_DIV_W    = 2'd0;
  localparam logic [1:0] MODE_DIV_FIVE = 2'd1;
  localparam logic [1:0] MODE_NONE     = 2'd2;

  localparam logic signed [WIDE_W-1:0] SAT_MAX = 50'sd2147483647;
  localparam logic signed [WIDE_W-1:0] SAT_MIN = -50'sd2147483648;

  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] in_w;
    logic [1:0]         project_mode;
  } vtp_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic               saturated;
  } vtp_out_t;

  // Transformed vertex, component order x, y, z, w.
  typedef struct packed {
    logic [3:0][WIDE_W-1:0] t;
    logic [1:0]             mode;
  } vtp_xf_t;

  // One divider lane set: three dividends share one divisor.
  typedef struct packed {
    logic [2:0][DIV_NUM_W-1:0] num;
    logic [2:0][DIV_DEN_W-1:0] rem;
    logic [2:0]                neg;
    logic [DIV_DEN_W-1:0]      den;
    logic signed [31:0]        w;
    logic                      flag;
  } vtp_div_t;

  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic ovf32(input logic signed [WIDE_W-1:0] v);
    return (v > SAT_MAX) || (v < SAT_MIN);
  endfunction

endpackage

// ===== hdl/vertex_transform_project.sv =====
// Top level: matrix registers and the transform, setup and divide pipeline.
//
//   channel  | direction | payload
//   vertex   | in        | vtp_in_t   (x, y, z, w, project_mode)
//   result   | out       | vtp_out_t  (x, y, z, w, saturated)
//   cfg      | in        | cfg_index, cfg_data (one 64-bit matrix register)
//
// One vertex per cycle in and out while the result side is not stalled; stages in order: the
// product, pair-sum and sum registers, the saturation and divide-setup register, 49 restoring
// divide steps (one quotient bit each) and the sign and clamp register.
// Synchronous reset clears all valid bits and loads the identity matrix.
// Each stage holds when the one after it is full and stalled; empty stages fill.
module vertex_transform_project
  import vtp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 vertex_valid,
  output logic                 vertex_ready,
  input  vtp_in_t              vertex,
  output logic                 result_valid,
  input  logic                 result_ready,
  output vtp_out_t             result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  logic [NUM_REGS-1:0][63:0] matrix;

  logic     xf_valid;
  logic     xf_ready;
  vtp_xf_t  xf;
  logic     dv_valid;
  logic     dv_ready;
  vtp_div_t dv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix[0] <= 64'h0000_0000_0001_0000;
      matrix[1] <= 64'h0;
      matrix[2] <= 64'h0001_0000_0000_0000;
      matrix[3] <= 64'h0;
      matrix[4] <= 64'h0;
      matrix[5] <= 64'h0000_0000_0001_0000;
      matrix[6] <= 64'h0;
      matrix[7] <= 64'h0001_0000_0000_0000;
    end else if (cfg_valid && cfg_ready) begin
      matrix[cfg_index] <= cfg_data;
    end
  end

  vtp_dot u_dot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vertex_valid),
    .in_ready  (vertex_ready),
    .vtx       (vertex),
    .matrix    (matrix),
    .out_valid (xf_valid),
    .out_ready (xf_ready),
    .xf        (xf)
  );

  vtp_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (xf_valid),
    .in_ready  (xf_ready),
    .xf        (xf),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .div       (dv)
  );

  vtp_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv_valid),
    .in_ready  (dv_ready),
    .div       (dv),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .res       (result)
  );

endmodule

// ===== hdl/vtp_dot.sv =====
// Matrix times vertex: products, pair sums, final sum with floor shift.
module vtp_dot
  import vtp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  vtp_in_t                    vtx,
  input  logic [NUM_REGS-1:0][63:0]  matrix,
  output logic                       out_valid,
  input  logic                       out_ready,
  output vtp_xf_t                    xf
);

  logic [2:0] vld;
  logic [2:0] adv;

  logic signed [63:0] prod [4][4];
  logic signed [64:0] pair [4][2];
  logic [1:0]         mode1;
  logic [1:0]         mode2;
  logic signed [31:0] vec  [4];

  assign adv[2]    = !vld[2] || out_ready;
  assign adv[1]    = !vld[1] || adv[2];
  assign adv[0]    = !vld[0] || adv[1];
  assign in_ready  = adv[0];
  assign out_valid = vld[2];

  assign vec[0] = vtx.in_x;
  assign vec[1] = vtx.in_y;
  assign vec[2] = vtx.in_z;
  assign vec[3] = vtx.in_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      if (adv[1]) vld[1] <= vld[0];
      if (adv[2]) vld[2] <= vld[1];
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      always_ff @(posedge clk) begin
        if (adv[0]) begin
          prod[r][c] <= $signed(matrix[r*2 + c/2][(c%2)*32 +: 32]) * vec[c];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv[1]) begin
        pair[r][0] <= 65'(prod[r][0]) + 65'(prod[r][1]);
        pair[r][1] <= 65'(prod[r][2]) + 65'(prod[r][3]);
      end
    end

    logic signed [65:0] total;
    assign total = 66'(pair[r][0]) + 66'(pair[r][1]);

    // Arithmetic shift of the exact sum rounds toward minus infinity.
    always_ff @(posedge clk) begin
      if (adv[2]) begin
        xf.t[r] <= WIDE_W'(total >>> FRAC_BITS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) mode1   <= vtx.project_mode;
    if (adv[1]) mode2   <= mode1;
    if (adv[2]) xf.mode <= mode2;
  end

endmodule

// ===== hdl/vtp_prep.sv =====
// Saturation and divide setup: picks dividend and divisor per projection mode.
module vtp_prep
  import vtp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  vtp_xf_t  xf,
  output logic     out_valid,
  input  logic     out_ready,
  output vtp_div_t div
);

  logic     vld;
  vtp_div_t nxt;

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;

  always_comb begin
    logic signed [31:0]       c_sat [3];
    logic [2:0]               c_ovf;
    logic signed [31:0]       w_sat;
    logic                     w_ovf;
    logic signed [WIDE_W-1:0] n_val [3];
    logic signed [31:0]       d_val;
    logic signed [WIDE_W-1:0] n_abs;

    w_sat = sat32($signed(xf.t[3]));
    w_ovf = ovf32($signed(xf.t[3]));
    for (int i = 0; i < 3; i++) begin
      c_sat[i] = sat32($signed(xf.t[i]));
      c_ovf[i] = ovf32($signed(xf.t[i]));
    end

    nxt = '0;
    d_val = 32'sd1;
    nxt.flag = w_ovf || (|c_ovf);
    for (int i = 0; i < 3; i++) begin
      n_val[i] = {{(WIDE_W-32){c_sat[i][31]}}, c_sat[i]};
    end

    unique case (xf.mode)
      MODE_DIV_W: begin
        if (w_sat != 32'sd0) begin
          d_val = w_sat;
          for (int i = 0; i < 3; i++) begin
            n_val[i] = {{(WIDE_W-32-FRAC_BITS){c_sat[i][31]}}, c_sat[i],
                        {FRAC_BITS{1'b0}}};
          end
        end
      end
      MODE_DIV_FIVE: begin
        d_val    = 32'sd5;
        nxt.flag = w_ovf;
        for (int i = 0; i < 3; i++) begin
          n_val[i] = $signed(xf.t[i]);
        end
      end
      default: begin
      end
    endcase

    for (int i = 0; i < 3; i++) begin
      n_abs      = n_val[i][WIDE_W-1] ? -n_val[i] : n_val[i];
      nxt.num[i] = n_abs[DIV_NUM_W-1:0];
      nxt.neg[i] = n_val[i][WIDE_W-1] ^ d_val[31];
    end
    nxt.den = d_val[31] ? (~d_val + 32'd1) : d_val;
    nxt.w   = w_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      div <= nxt;
    end
  end

endmodule

// ===== hdl/vtp_divider.sv =====
// Restoring divider, one quotient bit per stage, with sign and clamp at the end.
module vtp_divider
  import vtp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  vtp_div_t div,
  output logic     out_valid,
  input  logic     out_ready,
  output vtp_out_t res
);

  logic [DIV_STEPS:0] vld;
  logic [DIV_STEPS:0] adv;
  vtp_div_t           st [DIV_STEPS];

  assign adv[DIV_STEPS] = !vld[DIV_STEPS] || out_ready;
  assign in_ready       = adv[0];
  assign out_valid      = vld[DIV_STEPS];

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    vtp_div_t cur;
    vtp_div_t nxt;
    logic     prev_vld;

    assign adv[s] = !vld[s] || adv[s+1];

    if (s == 0) begin : g_first
      assign cur      = div;
      assign prev_vld = in_valid;
    end else begin : g_next
      assign cur      = st[s-1];
      assign prev_vld = vld[s-1];
    end

    always_comb begin
      logic [DIV_DEN_W:0] sh;
      logic               q;
      nxt = cur;
      for (int l = 0; l < 3; l++) begin
        sh = {cur.rem[l], cur.num[l][DIV_NUM_W-1]};
        q  = (sh >= {1'b0, cur.den});
        nxt.rem[l] = q ? DIV_DEN_W'(sh - {1'b0, cur.den}) : sh[DIV_DEN_W-1:0];
        nxt.num[l] = {cur.num[l][DIV_NUM_W-2:0], q};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (adv[s]) begin
        vld[s] <= prev_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[s]) begin
        st[s] <= nxt;
      end
    end
  end

  vtp_out_t fin;

  always_comb begin
    logic signed [31:0] val [3];
    logic               flag;
    logic [DIV_NUM_W-1:0] q;
    flag = st[DIV_STEPS-1].flag;
    for (int l = 0; l < 3; l++) begin
      q = st[DIV_STEPS-1].num[l];
      if (st[DIV_STEPS-1].neg[l]) begin
        if (q > DIV_NUM_W'(64'd2147483648)) begin
          val[l] = 32'sh80000000;
          flag   = 1'b1;
        end else begin
          val[l] = ~q[31:0] + 32'd1;
        end
      end else begin
        if (q > DIV_NUM_W'(64'd2147483647)) begin
          val[l] = 32'sh7FFFFFFF;
          flag   = 1'b1;
        end else begin
          val[l] = q[31:0];
        end
      end
    end
    fin.out_x     = val[0];
    fin.out_y     = val[1];
    fin.out_z     = val[2];
    fin.out_w     = st[DIV_STEPS-1].w;
    fin.saturated = flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[DIV_STEPS] <= 1'b0;
    end else if (adv[DIV_STEPS]) begin
      vld[DIV_STEPS] <= vld[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[DIV_STEPS]) begin
      res <= fin;
    end
  end

endmodule

// ===== tb/tb_vertex_transform_project.sv =====
// Testbench for vertex_transform_project: matrix transform, projection and saturation.
`timescale 1ns / 1ps

module tb_vertex_transform_project;
  import vtp_pkg::*;

  localparam int LATENCY  = 54;
  localparam int WDOG_MAX = 20000;

  typedef enum logic [2:0] {
    REG_ROW0_LEFT, REG_ROW0_RIGHT, REG_ROW1_LEFT, REG_ROW1_RIGHT,
    REG_ROW2_LEFT, REG_ROW2_RIGHT, REG_ROW3_LEFT, REG_ROW3_RIGHT
  } mat_reg_e;

  logic                 clk;
  logic                 rst;
  logic                 vertex_valid;
  logic                 vertex_ready;
  vtp_in_t              vertex;
  logic                 result_valid;
  logic                 result_ready;
  vtp_out_t             result;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0]          cfg_data;

  vertex_transform_project DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Model copy of the matrix registers
  logic [63:0] mat_regs [NUM_REGS];
  vtp_out_t    pending_results[$];
  int          errors;
  int          sent_cnt;
  int          recv_cnt;
  int          sat_cnt;
  int          idle_cnt;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic [3:0]  mode_seen;

  function automatic logic signed [63:0] mat_entry(int r, int c);
    logic [63:0] reg_val;
    reg_val = mat_regs[r * 2 + c / 2];
    return (c % 2) ? {{32{reg_val[63]}}, reg_val[63:32]}
                   : {{32{reg_val[31]}}, reg_val[31:0]};
  endfunction

  function automatic logic signed [127:0] clamp32(input logic signed [127:0] v,
                                                  inout logic flag);
    if (v > 128'sd2147483647) begin
      flag = 1'b1;
      return 128'sd2147483647;
    end
    if (v < -128'sd2147483648) begin
      flag = 1'b1;
      return -128'sd2147483648;
    end
    return v;
  endfunction

  function automatic vtp_out_t project_vertex(vtp_in_t v);
    logic signed [127:0] comp [4];
    logic signed [127:0] xf [4];
    logic signed [127:0] acc;
    logic signed [127:0] res [4];
    logic flag;
    vtp_out_t o;
    comp[0] = v.in_x;
    comp[1] = v.in_y;
    comp[2] = v.in_z;
    comp[3] = v.in_w;
    flag = 1'b0;
    for (int r = 0; r < 4; r++) begin
      acc = 0;
      for (int c = 0; c < 4; c++) acc += mat_entry(r, c) * comp[c];
      xf[r] = acc >>> 16;  // floor
    end
    res[3] = clamp32(xf[3], flag);
    if (v.project_mode == MODE_DIV_W) begin
      for (int i = 0; i < 3; i++) res[i] = clamp32(xf[i], flag);
      if (res[3] != 0)
        for (int i = 0; i < 3; i++) res[i] = clamp32((res[i] * 65536) / res[3], flag);
    end else if (v.project_mode == MODE_DIV_FIVE) begin
      for (int i = 0; i < 3; i++) res[i] = clamp32(xf[i] / 5, flag);
    end else begin
      for (int i = 0; i < 3; i++) res[i] = clamp32(xf[i], flag);
    end
    o.out_x = res[0][31:0];
    o.out_y = res[1][31:0];
    o.out_z = res[2][31:0];
    o.out_w = res[3][31:0];
    o.saturated = flag;
    return o;
  endfunction

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFFFFFF;
      1:       return 32'h80000000;
      2:       return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      3:       return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)) <<< 4;
      default: return $urandom();
    endcase
  endfunction

  // Leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(mat_reg_e idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mat_regs[idx] = val;
  endtask

  task automatic drain();
    vertex_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Leaves vertex_valid high; idle cycles and drain() drop it
  task automatic send_vertex(vtp_in_t v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      vertex_valid <= 1'b0;
      @(posedge clk);
    end
    vertex_valid <= 1'b1;
    vertex       <= v;
    @(posedge clk);
    while (!vertex_ready) @(posedge clk);
    pending_results.push_back(project_vertex(v));
    mode_seen[v.project_mode] = 1'b1;
    sent_cnt++;
  endtask

  task automatic load_random_matrix(int style);
    for (int i = 0; i < NUM_REGS; i++) begin
      case (style)
        0: write_reg(mat_reg_e'(i), {$urandom(), $urandom()});
        1: write_reg(mat_reg_e'(i), {32'h7FFFFFFF, 32'h80000000});
        default: write_reg(mat_reg_e'(i),
            {32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)),
             32'($signed($urandom_range(0, 1 << 18)) - (1 << 17))});
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stall and compare against the oldest prediction
  always @(posedge clk) begin
    vtp_out_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          want = pending_results.pop_front();
          recv_cnt++;
          if (result.saturated) sat_cnt++;
          if (result.out_x !== want.out_x) begin
            $error("out_x exp %h got %h", want.out_x, result.out_x); errors++;
          end
          if (result.out_y !== want.out_y) begin
            $error("out_y exp %h got %h", want.out_y, result.out_y); errors++;
          end
          if (result.out_z !== want.out_z) begin
            $error("out_z exp %h got %h", want.out_z, result.out_z); errors++;
          end
          if (result.out_w !== want.out_w) begin
            $error("out_w exp %h got %h", want.out_w, result.out_w); errors++;
          end
          if (result.saturated !== want.saturated) begin
            $error("saturated exp %b got %b", want.saturated, result.saturated); errors++;
          end
        end
      end
      result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: count cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (vertex_valid && vertex_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WDOG_MAX) begin
        $display("watchdog expired, %0d results outstanding", pending_results.size());
        $display("FAIL vertex_transform_project");
        $finish;
      end
    end
  end

  typedef struct {
    vtp_in_t  v;
    logic     known;
    vtp_out_t want;
  } dir_row_t;

  dir_row_t dir_rows [$];

  task automatic add_row(logic [31:0] x, y, z, w, logic [1:0] m,
                         logic known = 1'b0, vtp_out_t want = '0);
    dir_row_t r;
    r.v = '{in_x: x, in_y: y, in_z: z, in_w: w, project_mode: m};
    r.known = known;
    r.want = want;
    dir_rows.push_back(r);
  endtask

  initial begin
    vtp_in_t v;
    int phase_items;
    rst = 1'b1;
    vertex_valid = 1'b0;
    vertex = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0; sent_cnt = 0; recv_cnt = 0; sat_cnt = 0;
    mode_seen = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    mat_regs[REG_ROW0_LEFT]  = 64'd65536;
    mat_regs[REG_ROW0_RIGHT] = 64'd0;
    mat_regs[REG_ROW1_LEFT]  = 64'd65536 << 32;
    mat_regs[REG_ROW1_RIGHT] = 64'd0;
    mat_regs[REG_ROW2_LEFT]  = 64'd0;
    mat_regs[REG_ROW2_RIGHT] = 64'd65536;
    mat_regs[REG_ROW3_LEFT]  = 64'd0;
    mat_regs[REG_ROW3_RIGHT] = 64'd65536 << 32;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: identity matrix after reset, fields at their extremes
    add_row(32'h00010000, 32'h00020000, 32'h00030000, 32'h00010000, MODE_NONE,
            1'b1, '{32'h00010000, 32'h00020000, 32'h00030000, 32'h00010000, 1'b0});
    add_row(32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h0, MODE_DIV_W,
            1'b1, '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h0, 1'b0});
    add_row(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h1, MODE_DIV_W,
            1'b1, '{32'h7FFFFFFF, 32'h80000000, 32'hFFFF0000, 32'h1, 1'b1});
    add_row(32'h00050000, 32'hFFFB0000, 32'h7FFFFFFF, 32'h80000000, MODE_DIV_FIVE,
            1'b1, '{32'h00010000, 32'hFFFF0000, 32'h19999999, 32'h80000000, 1'b0});
    add_row(32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 2'd3,
            1'b1, '{32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b0});
    add_row(32'h00040000, 32'h00080000, 32'hFFFC0000, 32'h00020000, MODE_DIV_W,
            1'b1, '{32'h00020000, 32'h00040000, 32'hFFFE0000, 32'h00020000, 1'b0});
    add_row(32'h80000000, 32'h80000000, 32'h80000000, 32'hFFFFFFFF, MODE_DIV_W);
    add_row(32'h7FFFFFFF, 32'h00000001, 32'h80000000, 32'h80000000, MODE_DIV_W);
    add_row(32'hFFFFFFFB, 32'h00000004, 32'h00000006, 32'h0, MODE_DIV_FIVE);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].known && project_vertex(dir_rows[i].v) !== dir_rows[i].want) begin
        $error("directed row %0d: typed expectation disagrees with predictor", i);
        errors++;
      end
      send_vertex(dir_rows[i].v);
    end
    drain();

    // Saturating matrix, then a few extremes through it
    load_random_matrix(1);
    add_row(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, MODE_DIV_W);
    add_row(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, MODE_DIV_FIVE);
    add_row(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, MODE_NONE);
    for (int i = 9; i < dir_rows.size(); i++) send_vertex(dir_rows[i].v);
    drain();

    // Random phases: matrix changes only while idle
    for (int ph = 0; ph < 9; ph++) begin
      send_idle_pct = (ph < 3) ? 14 : (ph < 6) ? 79 : 0;
      recv_idle_pct = (ph < 3) ? 79 : (ph < 6) ? 14 : 0;
      load_random_matrix((ph % 3 == 1) ? 0 : 2);
      phase_items = 150;
      for (int n = 0; n < phase_items; n++) begin
        v.in_x = rand_comp();
        v.in_y = rand_comp();
        v.in_z = rand_comp();
        v.in_w = ($urandom_range(0, 9) == 0) ? 32'h0 : rand_comp();
        v.project_mode = 2'($urandom_range(0, 3));
        send_vertex(v);
        // Hold off once, midway through phase 4, until the pipe is empty
        if (n == 75 && ph == 4) begin
          vertex_valid <= 1'b0;
          @(posedge clk);
          while (pending_results.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    // Back to the reset values so the identity setting is revisited
    write_reg(REG_ROW0_LEFT, 64'd65536);
    write_reg(REG_ROW0_RIGHT, 64'd0);
    write_reg(REG_ROW1_LEFT, 64'd65536 << 32);
    write_reg(REG_ROW1_RIGHT, 64'd0);
    write_reg(REG_ROW2_LEFT, 64'd0);
    write_reg(REG_ROW2_RIGHT, 64'd65536);
    write_reg(REG_ROW3_LEFT, 64'd0);
    write_reg(REG_ROW3_RIGHT, 64'd65536 << 32);
    cfg_valid <= 1'b0;
    for (int n = 0; n < 30; n++) begin
      v = '{rand_comp(), rand_comp(), rand_comp(), rand_comp(), 2'($urandom_range(0, 3))};
      send_vertex(v);
    end
    drain();

    $display("%0d vertices sent, %0d results checked, %0d saturated, modes seen %b",
             sent_cnt, recv_cnt, sat_cnt, mode_seen);
    $display("matrix loads covered identity, full-scale and random settings");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS vertex_transform_project");
    end else begin
      $display("FAIL vertex_transform_project");
    end
    $finish;
  end

endmodule
